### sv/ctp_pkg.sv
// Package: widths, phase and event codes, register indexes and limits for the countdown timer.
`timescale 1ns / 1ps

package ctp_pkg;

   localparam int KindW    = 2;
   localparam int MinW     = 4;
   localparam int SecW     = 6;
   localparam int PhaseW   = 3;
   localparam int StartW   = 3;
   localparam int BuzzW    = 4;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 4;

   localparam logic [PhaseW-1:0] PH_SETTING  = 3'd0;
   localparam logic [PhaseW-1:0] PH_PRESTART = 3'd1;
   localparam logic [PhaseW-1:0] PH_RUNNING  = 3'd2;
   localparam logic [PhaseW-1:0] PH_PAUSED   = 3'd3;
   localparam logic [PhaseW-1:0] PH_ELAPSED  = 3'd4;

   localparam logic [KindW-1:0] EV_TICK = 2'd0;
   localparam logic [KindW-1:0] EV_FIRE = 2'd1;
   localparam logic [KindW-1:0] EV_UP   = 2'd2;
   localparam logic [KindW-1:0] EV_DOWN = 2'd3;

   localparam logic [CsrIdxW-1:0] CSR_START_DELAY = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_BUZZ_TICKS  = 1'd1;

   localparam logic [MinW-1:0]   MAX_MINUTES       = 4'd9;
   localparam logic [SecW-1:0]   MAX_SECONDS       = 6'd59;
   localparam logic [StartW-1:0] START_DELAY_RESET = 3'd3;
   localparam logic [BuzzW-1:0]  BUZZ_TICKS_RESET  = 4'd2;

endpackage

### sv/ctp_if.sv
// Interfaces: event channel and result channel of the countdown timer.
`timescale 1ns / 1ps

interface ctp_req_if;
   import ctp_pkg::*;

   logic              valid;
   logic              ready;
   logic [KindW-1:0]  kind;
   logic [MinW-1:0]   set_minutes;
   logic [SecW-1:0]   set_seconds;

   modport source (output valid, kind, set_minutes, set_seconds, input ready);
   modport sink   (input valid, kind, set_minutes, set_seconds, output ready);
endinterface

interface ctp_rsp_if;
   import ctp_pkg::*;

   logic              valid;
   logic              ready;
   logic [PhaseW-1:0] phase;
   logic [MinW-1:0]   minutes_left;
   logic [SecW-1:0]   seconds_left;
   logic [StartW-1:0] start_left;
   logic              buzzer_on;

   modport source (output valid, phase, minutes_left, seconds_left, start_left, buzzer_on,
                   input ready);
   modport sink   (input valid, phase, minutes_left, seconds_left, start_left, buzzer_on,
                   output ready);
endinterface

### sv/countdown_timer_pause_resume_top.sv
// Top level: countdown timer with pre-start countdown, pause, resume, restart, quit and buzzer.
//
//   port      direction  contents
//   req_bus   in         kind, set_minutes, set_seconds (valid/ready)
//   rsp_bus   out        phase, minutes_left, seconds_left, start_left, buzzer_on (valid/ready)
//   csr_*     in         write enable, index, data (start_delay, buzz_ticks)
//
// One event per cycle while the result is not stalled; each event passes the input register,
// then the result register that also updates the timer state, before its result is offered
// and can transfer.
// Reset is synchronous: setting phase, zero time, start_delay 3, buzz_ticks 2.
// A stalled result holds the result register; the input register keeps taking
// events until both registers are full.
`timescale 1ns / 1ps

module countdown_timer_pause_resume_top (
   input  logic                         clock,
   input  logic                         reset,
   ctp_req_if.sink                      req_bus,
   ctp_rsp_if.source                    rsp_bus,
   input  logic                         csr_we,
   input  logic [ctp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [ctp_pkg::CsrDataW-1:0] csr_wdata
);
   import ctp_pkg::*;

   logic              in_vld_ff, in_vld_in;
   logic [KindW-1:0]  in_kind_ff;
   logic [MinW-1:0]   in_min_ff;
   logic [SecW-1:0]   in_sec_ff;

   logic              out_vld_ff, out_vld_in;
   logic [PhaseW-1:0] out_phase_ff;
   logic [MinW-1:0]   out_min_ff;
   logic [SecW-1:0]   out_sec_ff;
   logic [StartW-1:0] out_start_ff;
   logic              out_buzz_ff;

   logic [StartW-1:0] start_delay_ff;
   logic [BuzzW-1:0]  buzz_ticks_ff;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [MinW-1:0]   rem_min_ff, rem_min_in;
   logic [SecW-1:0]   rem_sec_ff, rem_sec_in;
   logic [MinW-1:0]   lat_min_ff, lat_min_in;
   logic [SecW-1:0]   lat_sec_ff, lat_sec_in;
   logic [StartW-1:0] start_ff, start_in;
   logic [BuzzW-1:0]  buzz_ff, buzz_in;

   logic              advance;
   logic              take_in;
   logic [PhaseW-1:0] ph_eff;
   logic              rem_zero;
   logic [MinW-1:0]   dec_min;
   logic [SecW-1:0]   dec_sec;
   logic              dec_zero;
   logic [MinW-1:0]   clamp_min;
   logic [SecW-1:0]   clamp_sec;

   assign advance        = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_vld_ff || advance;
   assign take_in        = req_bus.valid && req_bus.ready;
   assign in_vld_in      = take_in || (in_vld_ff && !advance);
   assign out_vld_in     = advance || (out_vld_ff && !rsp_bus.ready);

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.phase        = out_phase_ff;
   assign rsp_bus.minutes_left = out_min_ff;
   assign rsp_bus.seconds_left = out_sec_ff;
   assign rsp_bus.start_left   = out_start_ff;
   assign rsp_bus.buzzer_on    = out_buzz_ff;

   assign ph_eff    = (phase_ff > PH_ELAPSED) ? PH_SETTING : phase_ff;
   assign rem_zero  = (rem_min_ff == '0) && (rem_sec_ff == '0);
   assign dec_sec   = (rem_sec_ff == '0) ? MAX_SECONDS : rem_sec_ff - SecW'(1);
   assign dec_min   = (rem_sec_ff == '0) ? rem_min_ff - MinW'(1) : rem_min_ff;
   assign dec_zero  = (dec_min == '0) && (dec_sec == '0);
   assign clamp_min = (in_min_ff > MAX_MINUTES) ? MAX_MINUTES : in_min_ff;
   assign clamp_sec = (in_sec_ff > MAX_SECONDS) ? MAX_SECONDS : in_sec_ff;

   always_comb begin
      phase_in   = ph_eff;
      rem_min_in = rem_min_ff;
      rem_sec_in = rem_sec_ff;
      lat_min_in = lat_min_ff;
      lat_sec_in = lat_sec_ff;
      start_in   = start_ff;
      buzz_in    = buzz_ff;
      unique case (in_kind_ff)
         EV_TICK: begin
            if (buzz_ff != '0) begin
               buzz_in = buzz_ff - BuzzW'(1);
            end
            if (ph_eff == PH_PRESTART && start_ff > StartW'(1)) begin
               start_in = start_ff - StartW'(1);
            end else if (ph_eff == PH_PRESTART || ph_eff == PH_RUNNING) begin
               start_in = (ph_eff == PH_PRESTART) ? '0 : start_ff;
               phase_in = PH_RUNNING;
               if (!rem_zero) begin
                  rem_min_in = dec_min;
                  rem_sec_in = dec_sec;
                  if (dec_zero) begin
                     phase_in = PH_ELAPSED;
                     buzz_in  = buzz_ticks_ff;
                  end
               end
            end
         end
         EV_FIRE: begin
            unique case (ph_eff)
               PH_RUNNING: phase_in = PH_PAUSED;
               PH_PAUSED:  phase_in = PH_RUNNING;
               PH_PRESTART: phase_in = PH_PRESTART;
               PH_ELAPSED: begin
                  phase_in = PH_SETTING;
                  start_in = '0;
                  buzz_in  = '0;
               end
               default: begin
                  lat_min_in = clamp_min;
                  lat_sec_in = clamp_sec;
                  rem_min_in = clamp_min;
                  rem_sec_in = clamp_sec;
                  start_in   = start_delay_ff;
                  buzz_in    = '0;
                  phase_in   = PH_PRESTART;
               end
            endcase
         end
         EV_UP: begin
            if (ph_eff == PH_PAUSED) begin
               rem_min_in = lat_min_ff;
               rem_sec_in = lat_sec_ff;
               phase_in   = PH_RUNNING;
            end
         end
         default: begin
            if (ph_eff == PH_PAUSED) begin
               phase_in = PH_SETTING;
               start_in = '0;
               buzz_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         start_delay_ff <= START_DELAY_RESET;
         buzz_ticks_ff  <= BUZZ_TICKS_RESET;
         phase_ff       <= PH_SETTING;
         rem_min_ff     <= '0;
         rem_sec_ff     <= '0;
         lat_min_ff     <= '0;
         lat_sec_ff     <= '0;
         start_ff       <= '0;
         buzz_ff        <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_START_DELAY: start_delay_ff <= csr_wdata[StartW-1:0];
               CSR_BUZZ_TICKS:  buzz_ticks_ff  <= csr_wdata[BuzzW-1:0];
               default: ;
            endcase
         end
         if (advance) begin
            phase_ff   <= phase_in;
            rem_min_ff <= rem_min_in;
            rem_sec_ff <= rem_sec_in;
            lat_min_ff <= lat_min_in;
            lat_sec_ff <= lat_sec_in;
            start_ff   <= start_in;
            buzz_ff    <= buzz_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_kind_ff <= req_bus.kind;
         in_min_ff  <= req_bus.set_minutes;
         in_sec_ff  <= req_bus.set_seconds;
      end
      if (advance) begin
         out_phase_ff <= phase_in;
         out_min_ff   <= rem_min_in;
         out_sec_ff   <= rem_sec_in;
         out_start_ff <= start_in;
         out_buzz_ff  <= (buzz_in != '0);
      end
   end

endmodule
